/* hw/rtl/clcd_pkg.sv */
// shared types, opcodes and microcode program of the character lcd write sequencer
`timescale 1ns / 1ps

package clcd_pkg;

  localparam logic [1:0] OP_INIT = 2'd0;
  localparam logic [1:0] OP_CMD  = 2'd1;
  localparam logic [1:0] OP_TEXT = 2'd2;
  localparam logic [1:0] OP_END  = 2'd3;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [15:0] DELAY_RESET = 16'd12001;

  localparam int PC_W = 4;

  // program entry points
  localparam logic [PC_W-1:0] PC_INIT = 4'd0;
  localparam logic [PC_W-1:0] PC_CMD  = 4'd7;
  localparam logic [PC_W-1:0] PC_TEXT = 4'd8;
  localparam logic [PC_W-1:0] PC_END  = 4'd10;

  // hold time in delay units
  localparam logic [1:0] UNITS_0 = 2'd0;
  localparam logic [1:0] UNITS_1 = 2'd1;
  localparam logic [1:0] UNITS_2 = 2'd2;

  // one control word: one byte transfer (or the pin clear state)
  typedef struct packed {
    logic       clear;    // all pins low, held zero ticks
    logic       src_in;   // byte comes from the input transaction
    logic [7:0] cbyte;    // constant byte when src_in is low
    logic       rs;       // rs for this byte
    logic       extra;    // last pin state held two units
    logic       cond_nl;  // jump over this word unless the input byte is a newline
    logic       end_run;  // final word of the run
  } ucode_t;

  typedef struct packed {
    logic [3:0] nib;
    logic       rs;
    logic       en;
    logic [1:0] units;
    logic       last;
  } pin_t;

  typedef struct packed {
    logic emit;       // pin state valid this cycle
    logic step_done;  // move to next control word
    logic run_done;   // run finished
  } gen_status_t;

  function automatic ucode_t mk(input logic clear, input logic src_in,
                                input logic [7:0] cbyte, input logic rs,
                                input logic extra, input logic cond_nl,
                                input logic end_run);
    ucode_t w;
    w.clear   = clear;
    w.src_in  = src_in;
    w.cbyte   = cbyte;
    w.rs      = rs;
    w.extra   = extra;
    w.cond_nl = cond_nl;
    w.end_run = end_run;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      4'd0:    w = mk(1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
      4'd1:    w = mk(1'b0, 1'b0, 8'h02, 1'b0, 1'b1, 1'b0, 1'b0);
      4'd2:    w = mk(1'b0, 1'b0, 8'h28, 1'b0, 1'b1, 1'b0, 1'b0);
      4'd3:    w = mk(1'b0, 1'b0, 8'h0C, 1'b0, 1'b1, 1'b0, 1'b0);
      4'd4:    w = mk(1'b0, 1'b0, 8'h06, 1'b0, 1'b1, 1'b0, 1'b0);
      4'd5:    w = mk(1'b0, 1'b0, 8'h01, 1'b0, 1'b1, 1'b0, 1'b0);
      4'd6:    w = mk(1'b0, 1'b0, 8'h80, 1'b0, 1'b1, 1'b0, 1'b1);
      4'd7:    w = mk(1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
      4'd8:    w = mk(1'b0, 1'b0, 8'hC0, 1'b0, 1'b1, 1'b1, 1'b0);
      4'd9:    w = mk(1'b0, 1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1);
      4'd10:   w = mk(1'b0, 1'b0, 8'h01, 1'b0, 1'b1, 1'b0, 1'b1);
      default: w = mk(1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
    endcase
    return w;
  endfunction

  function automatic logic [PC_W-1:0] entry_pc(input logic [1:0] op);
    logic [PC_W-1:0] pc;
    case (op)
      OP_INIT: pc = PC_INIT;
      OP_CMD:  pc = PC_CMD;
      OP_TEXT: pc = PC_TEXT;
      default: pc = PC_END;
    endcase
    return pc;
  endfunction

endpackage

/* hw/rtl/clcd_sequencer.sv */
// step counter and microcode table of the character lcd write sequencer
`timescale 1ns / 1ps

module clcd_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       opcode,
  input  logic             advance,
  output clcd_pkg::ucode_t word
);
  import clcd_pkg::*;

  logic [PC_W-1:0] pc;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_INIT;
    end else if (start) begin
      pc <= entry_pc(opcode);
    end else if (advance) begin
      pc <= pc + 1'b1;
    end
  end

  assign word = ucode_rom(pc);

endmodule

/* hw/rtl/clcd_pin_gen.sv */
// nibble phase counter and pin state datapath of the character lcd write sequencer
`timescale 1ns / 1ps

module clcd_pin_gen (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  step_en,
  input  clcd_pkg::ucode_t      word,
  input  logic [7:0]            byte_value,
  output clcd_pkg::pin_t        pin,
  output clcd_pkg::gen_status_t status
);
  import clcd_pkg::*;

  logic [2:0] phase;
  logic       rs_level;
  logic [7:0] cur_byte;
  logic       skip;
  logic       byte_end;

  assign skip     = word.cond_nl && (byte_value != CHAR_NEWLINE);
  assign cur_byte = word.src_in ? byte_value : word.cbyte;
  assign byte_end = word.clear || (phase == 3'd5);

  always_comb begin
    pin.nib   = (phase < 3'd3) ? cur_byte[7:4] : cur_byte[3:0];
    pin.rs    = (phase == 3'd0) ? rs_level : word.rs;
    pin.en    = (phase == 3'd1) || (phase == 3'd4);
    pin.units = UNITS_1;
    pin.last  = 1'b0;
    if (word.clear) begin
      pin.nib   = 4'h0;
      pin.rs    = 1'b0;
      pin.en    = 1'b0;
      pin.units = UNITS_0;
    end else if (phase == 3'd5) begin
      pin.units = word.extra ? UNITS_2 : UNITS_1;
      pin.last  = word.end_run;
    end
    status.emit      = step_en && !skip;
    status.step_done = step_en && (skip || byte_end);
    status.run_done  = step_en && !skip && byte_end && word.end_run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= 3'd0;
      rs_level <= 1'b0;
    end else if (start) begin
      phase <= 3'd0;
    end else if (step_en && !skip) begin
      if (byte_end) begin
        phase    <= 3'd0;
        rs_level <= word.clear ? 1'b0 : word.rs;
      end else begin
        phase <= phase + 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/char_lcd_nibble_write_sequencer.sv */
// top level of the character lcd 4-bit write sequencer
`timescale 1ns / 1ps

// Turns lcd operations into a run of pin states for a 4-bit character lcd bus.
// s_axis: one transaction per operation; tuser carries the opcode (init, raw
// command, text character, end of string), tdata the command or character byte.
// m_axis: one transaction per pin state with its hold time; tlast marks the
// final pin state of the operation's run.
// cfg_we / cfg_data write the delay unit in ticks; hold times are 0, 1 or 2 units.
// The first pin state is registered in the output register once the accept has
// set busy, then one pin state per cycle while m_axis_tready is high. A run is 37
// states for init, 12 for a newline character, 6 otherwise; a text character
// that is not a newline also spends a step without a pin state on the microcode
// jump over the newline command.
// The rate is set by the nibble phase counter walking one pin state a cycle.
// s_axis_tready is low while a run is in progress and returns as soon as the
// last pin state is in the output register, even if it is not yet taken.
// A stall on m_axis freezes the sequencer; nothing is dropped.
// Reset clears the kept RS level, empties the output register and loads the
// delay unit with 12001.
module char_lcd_nibble_write_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [3:0] data_nibble, [4] reg_select,
                                      // [5] read_write, [6] enable_line,
                                      // [23:7] hold_ticks
  output logic        m_axis_tlast    // last_of_run
);
  import clcd_pkg::*;

  logic        busy;
  logic [15:0] delay_ticks;
  logic [7:0]  byte_reg;
  logic        start;
  logic        out_free;
  logic        step_en;
  ucode_t      word;
  pin_t        pin;
  gen_status_t status;
  logic [16:0] hold;

  assign s_axis_tready = !busy;
  assign start         = s_axis_tvalid && s_axis_tready;
  // output register free, or its transaction completes this cycle
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign step_en       = busy && out_free;

  clcd_sequencer u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .opcode  (s_axis_tuser),
    .advance (status.step_done),
    .word    (word)
  );

  clcd_pin_gen u_pin (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .step_en    (step_en),
    .word       (word),
    .byte_value (byte_reg),
    .pin        (pin),
    .status     (status)
  );

  // hold time: zero, one or two delay units
  always_comb begin
    case (pin.units)
      UNITS_0: hold = 17'd0;
      UNITS_2: hold = {delay_ticks, 1'b0};
      default: hold = {1'b0, delay_ticks};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks <= DELAY_RESET;
    end else if (cfg_we) begin
      delay_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (status.run_done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      byte_reg <= s_axis_tdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= status.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (status.emit) begin
      m_axis_tdata <= {hold, pin.en, 1'b0, pin.rs, pin.nib};
      m_axis_tlast <= pin.last;
    end
  end

endmodule

/* test/char_lcd_nibble_write_sequencer_tb.sv */
// self-checking testbench for the character lcd 4-bit write sequencer
`timescale 1ns / 1ps

module char_lcd_nibble_write_sequencer_tb;

  import clcd_pkg::*;

  // command bytes the sequencer issues on its own
  localparam logic [7:0]  CMD_CLEAR = 8'h01;
  localparam logic [7:0]  CMD_LINE2 = 8'hC0;
  // power-up command list, first command in the lowest byte
  localparam logic [47:0] INIT_SEQ  = {8'h80, 8'h01, 8'h06, 8'h0C, 8'h28, 8'h02};
  localparam int          STALL_LIMIT = 2000;

  // one pin state as it appears on m_axis
  typedef struct packed {
    logic [3:0]  nib;
    logic        rs;
    logic        rw;
    logic        en;
    logic [16:0] hold;
    logic        last;
  } pin_state_t;

  // one lcd operation as it goes into s_axis
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] value;
  } lcd_op_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;  // [7:0] byte_value
  logic [1:0]  s_axis_tuser = '0;  // [1:0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;       // [3:0] nibble, [4] rs, [5] rw, [6] en, [23:7] hold
  logic        m_axis_tlast;       // last_of_run

  // stimulus and scoreboard state
  lcd_op_t    pending_ops[$];
  pin_state_t expected_pins[$];
  logic [15:0] lcd_delay = DELAY_RESET;  // mirror of the delay unit register
  logic        kept_rs = 1'b0;           // rs level left on the pins by the last byte
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          quiet_cycles = 0;
  int          op_count = 0;

  wire s_fire = s_axis_tvalid && s_axis_tready;
  wire m_fire = m_axis_tvalid && m_axis_tready;

  char_lcd_nibble_write_sequencer i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // pin state predictor
  // ---------------------------------------------------------------------------

  // hold time is a whole number of delay units taken from the current register
  function automatic void push_pin(input logic [3:0] nib, input logic rs,
                                   input logic en, input logic [1:0] units);
    pin_state_t p;
    p.nib  = nib;
    p.rs   = rs;
    p.rw   = 1'b0;
    p.en   = en;
    p.hold = {1'b0, lcd_delay} * {15'd0, units};
    p.last = 1'b0;
    expected_pins.push_back(p);
  endfunction

  // high nibble then low nibble, each as data set / en high / en low;
  // the very first state still shows the old rs since data moves before rs
  function automatic void push_byte(input logic [7:0] b, input logic rs,
                                    input logic long_tail);
    push_pin(b[7:4], kept_rs, 1'b0, UNITS_1);
    push_pin(b[7:4], rs, 1'b1, UNITS_1);
    push_pin(b[7:4], rs, 1'b0, UNITS_1);
    push_pin(b[3:0], rs, 1'b0, UNITS_1);
    push_pin(b[3:0], rs, 1'b1, UNITS_1);
    push_pin(b[3:0], rs, 1'b0, long_tail ? UNITS_2 : UNITS_1);
    kept_rs = rs;
  endfunction

  function automatic void predict_lcd_op(input logic [1:0] op, input logic [7:0] b);
    pin_state_t tail;
    case (op)
      OP_INIT: begin
        // all pins cleared for zero ticks, then the power-up command list
        push_pin(4'h0, 1'b0, 1'b0, UNITS_0);
        kept_rs = 1'b0;
        for (int i = 0; i < 6; i++) push_byte(INIT_SEQ[8*i +: 8], 1'b0, 1'b1);
      end
      OP_CMD: push_byte(b, 1'b0, 1'b0);
      OP_TEXT: begin
        // a newline moves the cursor to line two but is still written as data
        if (b == CHAR_NEWLINE) push_byte(CMD_LINE2, 1'b0, 1'b1);
        push_byte(b, 1'b1, 1'b0);
      end
      default: push_byte(CMD_CLEAR, 1'b0, 1'b1);
    endcase
    tail = expected_pins.pop_back();
    tail.last = 1'b1;
    expected_pins.push_back(tail);
  endfunction

  // ---------------------------------------------------------------------------
  // s_axis driver: one operation per transaction, random idle bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : op_driver
    logic    valid_n;
    lcd_op_t item;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      valid_n = s_axis_tvalid;
      if (s_fire) predict_lcd_op(s_axis_tuser, s_axis_tdata);
      // a presented operation stays put until the transaction completes
      if (!s_axis_tvalid || s_fire) begin
        if (send_gap > 0) begin
          send_gap--;
          valid_n = 1'b0;
        end else if ($urandom_range(0, 99) < send_idle_pct) begin
          send_gap = $urandom_range(0, 12);
          valid_n = 1'b0;
        end else if (pending_ops.size() > 0) begin
          item = pending_ops.pop_front();
          s_axis_tuser <= item.op;
          s_axis_tdata <= item.value;
          valid_n = 1'b1;
        end else begin
          valid_n = 1'b0;
        end
      end
      s_axis_tvalid <= valid_n;
    end
  end

  // ---------------------------------------------------------------------------
  // m_axis monitor: compare each pin state against the oldest prediction
  // ---------------------------------------------------------------------------
  function automatic void flag_field(input string field, input int want, input int got);
    errors++;
    $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, field, want, got);
  endfunction

  always @(posedge clk) begin : pin_monitor
    logic       ready_n;
    pin_state_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_fire) begin
        if (expected_pins.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected pin state, expected none actual %h last %b",
                   $time, m_axis_tdata, m_axis_tlast);
        end else begin
          want = expected_pins.pop_front();
          if (m_axis_tdata[3:0] !== want.nib)
            flag_field("data_nibble", want.nib, m_axis_tdata[3:0]);
          if (m_axis_tdata[4] !== want.rs)
            flag_field("reg_select", want.rs, m_axis_tdata[4]);
          if (m_axis_tdata[5] !== want.rw)
            flag_field("read_write", want.rw, m_axis_tdata[5]);
          if (m_axis_tdata[6] !== want.en)
            flag_field("enable_line", want.en, m_axis_tdata[6]);
          if (m_axis_tdata[23:7] !== want.hold)
            flag_field("hold_ticks", want.hold, m_axis_tdata[23:7]);
          if (m_axis_tlast !== want.last)
            flag_field("last_of_run", want.last, m_axis_tlast);
        end
      end
      // backpressure in bursts so stalls can land on any step of a run
      if (recv_gap > 0) begin
        recv_gap--;
        ready_n = 1'b0;
      end else if ($urandom_range(0, 99) < recv_idle_pct) begin
        recv_gap = $urandom_range(0, 12);
        ready_n = 1'b0;
      end else begin
        ready_n = 1'b1;
      end
      m_axis_tready <= ready_n;
    end
  end

  // watchdog: too long without any transaction on either side
  always @(posedge clk) begin
    if (rst || s_fire || m_fire) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("char_lcd_nibble_write_sequencer regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus plan
  // ---------------------------------------------------------------------------
  function automatic void add_op(input logic [1:0] op, input logic [7:0] b);
    lcd_op_t item;
    item.op    = op;
    item.value = b;
    pending_ops.push_back(item);
    op_count++;
  endfunction

  // mostly well-formed strings (optional init, characters and commands, end of string),
  // with some stray operations and some strings that never get terminated
  function automatic void add_random_ops(input int n);
    int target;
    int len;
    int pick;
    target = op_count + n;
    while (op_count < target) begin
      if ($urandom_range(0, 9) == 0) begin
        add_op(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 4) == 0) add_op(OP_INIT, 8'($urandom_range(0, 255)));
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          pick = $urandom_range(0, 99);
          if (pick < 12)      add_op(OP_TEXT, CHAR_NEWLINE);
          else if (pick < 20) add_op(OP_CMD, 8'($urandom_range(0, 255)));
          else if (pick < 75) add_op(OP_TEXT, 8'($urandom_range(8'h20, 8'h7E)));
          else                add_op(OP_TEXT, 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 7) != 0) add_op(OP_END, 8'($urandom_range(0, 255)));
      end
    end
  endfunction

  // block until the sender is empty and every predicted pin state has arrived
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_ops.size() != 0 || s_axis_tvalid || expected_pins.size() != 0);
  endtask

  // register write only while the sequencer sits idle
  task automatic write_delay(input logic [15:0] value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    lcd_delay = value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [15:0] phase_delay[5];
    phase_delay[0] = 16'hFFFF;                      // largest unit
    phase_delay[1] = 16'h0000;                      // zero unit, every hold is zero
    phase_delay[2] = 16'h0001;                      // smallest nonzero unit
    phase_delay[3] = 16'($urandom_range(2, 65534));
    phase_delay[4] = 16'($urandom_range(0, 65535));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part at the reset delay unit, no idling
    add_op(OP_INIT, 8'hFF);
    add_op(OP_TEXT, CHAR_NEWLINE);   // newline right after init
    add_op(OP_CMD, 8'h00);
    add_op(OP_CMD, 8'hFF);
    add_op(OP_TEXT, 8'h41);          // rs carried from command into data
    add_op(OP_CMD, 8'hA5);           // rs carried from data into command
    add_op(OP_TEXT, 8'h00);
    add_op(OP_TEXT, 8'hFF);
    add_op(OP_TEXT, CHAR_NEWLINE);
    add_op(OP_TEXT, CHAR_NEWLINE);   // back-to-back newlines
    add_op(OP_TEXT, 8'h0B);          // neighbors of the newline code
    add_op(OP_TEXT, 8'h09);
    add_op(OP_END, CHAR_NEWLINE);    // byte ignored on end of string
    add_op(OP_END, 8'h00);
    add_op(OP_CMD, 8'h5A);
    add_op(OP_TEXT, 8'h7E);
    add_op(OP_INIT, 8'h00);          // init with rs left high
    add_op(OP_END, 8'hFF);
    wait_drained();

    // random phases under different delay units; the sender always drains
    // completely before each register write
    for (int ph = 0; ph < 5; ph++) begin
      write_delay(phase_delay[ph]);
      if (ph == 4) begin
        // closing stretch runs flat out on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = (ph == 2) ? 0 : 12;
        recv_idle_pct = (ph == 1) ? 0 : 15;
      end
      add_random_ops(66);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && expected_pins.size() == 0) begin
      $display("char_lcd_nibble_write_sequencer regression: pass");
    end else begin
      $display("char_lcd_nibble_write_sequencer regression: fail");
    end
    $finish;
  end

endmodule
